/* hw/rtl/depq_pkg.sv */
// ----------------------------------------------------------------------------
// depq_pkg
// shared types, constants and helpers for the double-ended priority queue
// ----------------------------------------------------------------------------
package depq_pkg;

  localparam int CAPACITY       = 64;
  localparam int VALUE_BITS     = 32;
  localparam int FIELD_BITS     = 32;
  localparam int CNT_FIELD_BITS = 7;
  localparam int REQ_BITS       = 3;
  localparam int STATUS_BITS    = 2;
  localparam int IDX_BITS       = $clog2(CAPACITY);
  localparam int CNT_BITS       = $clog2(CAPACITY + 1);

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [CNT_BITS-1:0]          count_t;
  typedef logic [IDX_BITS-1:0]          idx_t;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_INSERT  = 3'd0,
    REQ_POP_MIN = 3'd1,
    REQ_POP_MAX = 3'd2,
    REQ_ERASE   = 3'd3,
    REQ_COUNT   = 3'd4,
    REQ_CLEAR   = 3'd5
  } req_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // what every cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT_ALL,
    CELL_SHIFT_GE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    value_t   key;
  } cell_ctrl_t;

  // stored value to result field: zero-extend or truncate the raw bits
  function automatic logic [FIELD_BITS-1:0] to_field(value_t v);
    logic [FIELD_BITS+VALUE_BITS-1:0] w;
    w = {{FIELD_BITS{1'b0}}, v};
    return w[FIELD_BITS-1:0];
  endfunction

  // input field to stored value: low bits taken as a signed value
  function automatic value_t from_field(logic [FIELD_BITS-1:0] f);
    logic [FIELD_BITS+VALUE_BITS-1:0] w;
    w = {{VALUE_BITS{1'b0}}, f};
    return value_t'(w[VALUE_BITS-1:0]);
  endfunction

  function automatic logic [CNT_FIELD_BITS-1:0] to_cnt_field(count_t c);
    logic [CNT_FIELD_BITS+CNT_BITS-1:0] w;
    w = {{CNT_FIELD_BITS{1'b0}}, c};
    return w[CNT_FIELD_BITS-1:0];
  endfunction

endpackage

/* hw/rtl/depq_cell.sv */
// ----------------------------------------------------------------------------
// depq_cell
// one slot of the sorted row: holds a value, compares it with the key and
// takes its own, its neighbor's or the key's value each cycle
// ----------------------------------------------------------------------------
module depq_cell (
  input  logic                   clk,
  input  depq_pkg::cell_ctrl_t   ctrl,
  input  logic                   valid,
  input  depq_pkg::value_t       left_value,
  input  logic                   left_gt,
  input  depq_pkg::value_t       right_value,
  output depq_pkg::value_t       value,
  output logic                   gt,
  output logic                   ge
);

  depq_pkg::value_t value_next;

  // empty slots count as larger than any key
  assign gt = !valid || ($signed(value) >  $signed(ctrl.key));
  assign ge = !valid || ($signed(value) >= $signed(ctrl.key));

  always_comb begin
    value_next = value;
    unique case (ctrl.op)
      depq_pkg::CELL_INSERT: begin
        if (left_gt) begin
          value_next = left_value;
        end else if (gt) begin
          value_next = ctrl.key;
        end
      end
      depq_pkg::CELL_SHIFT_ALL: value_next = right_value;
      depq_pkg::CELL_SHIFT_GE: begin
        if (ge) begin
          value_next = right_value;
        end
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

/* hw/rtl/depq_edge_enc.sv */
// ----------------------------------------------------------------------------
// depq_edge_enc
// position of the first set bit of a thermometer vector (zeros then ones)
// ----------------------------------------------------------------------------
module depq_edge_enc (
  input  logic [depq_pkg::CAPACITY-1:0] flags,
  output depq_pkg::count_t              first
);

  logic [depq_pkg::CAPACITY-1:0] lower;
  logic [depq_pkg::CAPACITY-1:0] rise_bits;

  assign lower     = {flags[depq_pkg::CAPACITY-2:0], 1'b0};
  assign rise_bits = flags & ~lower;

  // at most one rise bit is set, so an or of the indexes encodes it
  always_comb begin
    first = '0;
    for (int i = 0; i < depq_pkg::CAPACITY; i++) begin
      if (rise_bits[i]) begin
        first = first | depq_pkg::count_t'(i);
      end
    end
    if (flags == '0) begin
      first = depq_pkg::count_t'(depq_pkg::CAPACITY);
    end
  end

endmodule

/* hw/rtl/double_ended_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// double_ended_priority_queue_core
// bounded sorted multiset of signed values in a row of compare-and-shift cells
// ----------------------------------------------------------------------------
// Takes one request per clock: busy never rises, so start may be held high
// every cycle. The result of a request is shown for exactly one cycle, with
// done high, in the cycle right after the transfer; it cannot be held off and
// must be captured then. Every cell compares its value with the request key
// at once and all cells move at the same edge, whatever the occupancy. Min,
// max, occupancy and the empty flag describe the store after the request.
// The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_core (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [depq_pkg::REQ_BITS-1:0]           req_type,
  input  logic signed [depq_pkg::FIELD_BITS-1:0]  item_value,
  output logic                                    done,
  output logic [depq_pkg::STATUS_BITS-1:0]        status,
  output logic signed [depq_pkg::FIELD_BITS-1:0]  removed_value,
  output logic [depq_pkg::CNT_FIELD_BITS-1:0]     match_count,
  output logic signed [depq_pkg::FIELD_BITS-1:0]  min_value,
  output logic signed [depq_pkg::FIELD_BITS-1:0]  max_value,
  output logic [depq_pkg::CNT_FIELD_BITS-1:0]     occupancy,
  output logic                                    is_empty
);

  localparam int N = depq_pkg::CAPACITY;

  // number of values held; the cells below it are valid
  depq_pkg::count_t count;
  depq_pkg::count_t count_next;

  // result fields captured at the transfer
  depq_pkg::status_t                 status_q;
  depq_pkg::status_t                 status_next;
  logic [depq_pkg::FIELD_BITS-1:0]   removed_q;
  logic [depq_pkg::FIELD_BITS-1:0]   removed_next;
  depq_pkg::count_t                  match_q;
  depq_pkg::count_t                  match_next;

  depq_pkg::cell_ctrl_t  ctrl;
  depq_pkg::value_t      key;
  depq_pkg::value_t      cell_value [N];
  logic [N-1:0]          valid;
  logic [N-1:0]          gt_vec;
  logic [N-1:0]          ge_vec;
  depq_pkg::count_t      first_gt;
  depq_pkg::count_t      first_ge;
  depq_pkg::value_t      top_value;
  logic                  accept;
  logic                  found;
  logic                  store_empty;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign key    = depq_pkg::from_field(item_value);

  // ---------------------------------------------------------------- cell row
  for (genvar i = 0; i < N; i++) begin : g_cell
    depq_pkg::value_t left_value;
    depq_pkg::value_t right_value;
    logic             left_gt;

    assign valid[i] = count > depq_pkg::count_t'(i);

    if (i == 0) begin : g_first
      assign left_value = key;
      assign left_gt    = 1'b0;
    end else begin : g_inner
      assign left_value = cell_value[i-1];
      assign left_gt    = gt_vec[i-1];
    end

    // last cell pulls in its own value; it leaves the valid range anyway
    if (i == N - 1) begin : g_last
      assign right_value = cell_value[i];
    end else begin : g_body
      assign right_value = cell_value[i+1];
    end

    depq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .valid       (valid[i]),
      .left_value  (left_value),
      .left_gt     (left_gt),
      .right_value (right_value),
      .value       (cell_value[i]),
      .gt          (gt_vec[i]),
      .ge          (ge_vec[i])
    );
  end

  // both flag vectors are thermometers over the sorted row
  depq_edge_enc u_enc_gt (
    .flags (gt_vec),
    .first (first_gt)
  );

  depq_edge_enc u_enc_ge (
    .flags (ge_vec),
    .first (first_ge)
  );

  // copies of the key sit between the first >= cell and the first > cell
  assign found       = first_gt != first_ge;
  assign store_empty = count == '0;

  // largest held value, read from the current row
  assign top_value = cell_value[depq_pkg::idx_t'(count - depq_pkg::count_t'(1))];

  // ----------------------------------------------------- request decode
  always_comb begin
    ctrl.key     = key;
    ctrl.op      = depq_pkg::CELL_HOLD;
    count_next   = count;
    status_next  = depq_pkg::ST_OK;
    removed_next = '0;
    match_next   = '0;
    if (accept) begin
      unique case (req_type)
        depq_pkg::REQ_INSERT: begin
          if (count == depq_pkg::count_t'(N)) begin
            status_next = depq_pkg::ST_FULL;
          end else begin
            // new copy lands after equal values already held
            ctrl.op    = depq_pkg::CELL_INSERT;
            count_next = count + depq_pkg::count_t'(1);
          end
        end
        depq_pkg::REQ_POP_MIN: begin
          if (store_empty) begin
            status_next = depq_pkg::ST_EMPTY;
          end else begin
            ctrl.op      = depq_pkg::CELL_SHIFT_ALL;
            removed_next = depq_pkg::to_field(cell_value[0]);
            count_next   = count - depq_pkg::count_t'(1);
          end
        end
        depq_pkg::REQ_POP_MAX: begin
          if (store_empty) begin
            status_next = depq_pkg::ST_EMPTY;
          end else begin
            removed_next = depq_pkg::to_field(top_value);
            count_next   = count - depq_pkg::count_t'(1);
          end
        end
        depq_pkg::REQ_ERASE: begin
          if (found) begin
            // close the gap at the first copy
            ctrl.op      = depq_pkg::CELL_SHIFT_GE;
            removed_next = depq_pkg::to_field(key);
            count_next   = count - depq_pkg::count_t'(1);
          end else begin
            status_next = depq_pkg::ST_NOT_FOUND;
          end
        end
        depq_pkg::REQ_COUNT: begin
          match_next = first_gt - first_ge;
        end
        depq_pkg::REQ_CLEAR: begin
          count_next = '0;
        end
        default: begin
          // undefined request codes leave the store alone
          count_next = count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    status_q  <= status_next;
    removed_q <= removed_next;
    match_q   <= match_next;
  end

  // ---------------------------------------------------------------- result
  // store fields come straight from the row, which already holds the new state
  assign status        = status_q;
  assign removed_value = removed_q;
  assign match_count   = depq_pkg::to_cnt_field(match_q);
  assign min_value     = store_empty ? '0 : depq_pkg::to_field(cell_value[0]);
  assign max_value     = store_empty ? '0 : depq_pkg::to_field(top_value);
  assign occupancy     = depq_pkg::to_cnt_field(count);
  assign is_empty      = store_empty;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the double-ended priority queue core
// ----------------------------------------------------------------------------
// A short table of directed requests covers the empty, full and not-found
// paths, undefined request codes, the value extremes and a 64-deep fill of
// one duplicate value. Random bursts that lean toward filling, draining or
// mixed traffic follow, in phases with and without sender idle cycles.
// Results are checked field by field against typed rows or a sorted predictor.
// ----------------------------------------------------------------------------
module tb_top;

  localparam time    CLK_HALF     = 6ns;
  localparam int     PHASE_ITEMS  = 275;
  localparam int     DRAIN_LIMIT  = 1000;
  localparam logic [depq_pkg::REQ_BITS-1:0] REQ_UNDEF_LO = 3'd6;
  localparam logic [depq_pkg::REQ_BITS-1:0] REQ_UNDEF_HI = 3'd7;

  typedef struct {
    depq_pkg::status_t                   st;
    depq_pkg::value_t                    removed;
    logic [depq_pkg::CNT_FIELD_BITS-1:0] match_cnt;
    depq_pkg::value_t                    lo;
    depq_pkg::value_t                    hi;
    logic [depq_pkg::CNT_FIELD_BITS-1:0] occ;
    logic                                empt;
  } depq_result_t;

  typedef struct {
    logic [depq_pkg::REQ_BITS-1:0] req;
    depq_pkg::value_t              val;
    int                            reps;
    bit                            typed;
    depq_result_t                  exp;
  } stim_row_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                start = 1'b0;
  logic [depq_pkg::REQ_BITS-1:0]       req_type = '0;
  depq_pkg::value_t                    item_value = '0;
  logic                                busy;
  logic                                done;
  logic [depq_pkg::STATUS_BITS-1:0]    status;
  depq_pkg::value_t                    removed_value;
  logic [depq_pkg::CNT_FIELD_BITS-1:0] match_count;
  depq_pkg::value_t                    min_value;
  depq_pkg::value_t                    max_value;
  logic [depq_pkg::CNT_FIELD_BITS-1:0] occupancy;
  logic                                is_empty;

  // typed expectation travels with the request it belongs to
  bit           row_typed = 1'b0;
  depq_result_t row_exp;

  depq_pkg::value_t model_vals[$];       // predictor copy of the store, ascending
  depq_result_t     pending_results[$];  // expected results, oldest first
  int               fails = 0;

  always #(CLK_HALF) clk = ~clk;

  double_ended_priority_queue_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .item_value   (item_value),
    .done         (done),
    .status       (status),
    .removed_value(removed_value),
    .match_count  (match_count),
    .min_value    (min_value),
    .max_value    (max_value),
    .occupancy    (occupancy),
    .is_empty     (is_empty)
  );

  // apply one request to the sorted model and report the store afterwards
  function automatic depq_result_t depq_apply(logic [depq_pkg::REQ_BITS-1:0] req,
                                              depq_pkg::value_t v);
    depq_result_t r;
    int           pos;
    int           hits;
    bit           found;
    r.st      = depq_pkg::ST_OK;
    r.removed = '0;
    hits      = 0;
    found     = 1'b0;
    case (req)
      depq_pkg::REQ_INSERT: begin
        if (model_vals.size() >= depq_pkg::CAPACITY) begin
          r.st = depq_pkg::ST_FULL;
        end else begin
          // a new copy lands after the equal copies already held
          pos = model_vals.size();
          while (pos > 0 && model_vals[pos-1] > v) pos--;
          model_vals.insert(pos, v);
        end
      end
      depq_pkg::REQ_POP_MIN: begin
        if (model_vals.size() == 0) r.st = depq_pkg::ST_EMPTY;
        else r.removed = model_vals.pop_front();
      end
      depq_pkg::REQ_POP_MAX: begin
        if (model_vals.size() == 0) r.st = depq_pkg::ST_EMPTY;
        else r.removed = model_vals.pop_back();
      end
      depq_pkg::REQ_ERASE: begin
        for (pos = 0; pos < model_vals.size() && !found; pos++) begin
          if (model_vals[pos] == v) begin
            found = 1'b1;
            model_vals.delete(pos);
          end
        end
        if (found) r.removed = v;
        else r.st = depq_pkg::ST_NOT_FOUND;
      end
      depq_pkg::REQ_COUNT: begin
        foreach (model_vals[k]) if (model_vals[k] == v) hits++;
      end
      depq_pkg::REQ_CLEAR: begin
        model_vals.delete();
      end
      default: begin
        // undefined codes leave the store alone
      end
    endcase
    r.match_cnt = hits[depq_pkg::CNT_FIELD_BITS-1:0];
    r.occ       = depq_pkg::CNT_FIELD_BITS'(model_vals.size());
    r.empt      = (model_vals.size() == 0);
    r.lo        = r.empt ? depq_pkg::value_t'(0) : model_vals[0];
    r.hi        = r.empt ? depq_pkg::value_t'(0) : model_vals[model_vals.size()-1];
    return r;
  endfunction

  task automatic compare_result(depq_result_t got, depq_result_t want);
    if (got.st !== want.st) begin
      $error("status: expected %0d, got %0d", want.st, got.st);
      fails++;
    end
    if (got.removed !== want.removed) begin
      $error("removed_value: expected %0d, got %0d", want.removed, got.removed);
      fails++;
    end
    if (got.match_cnt !== want.match_cnt) begin
      $error("match_count: expected %0d, got %0d", want.match_cnt, got.match_cnt);
      fails++;
    end
    if (got.lo !== want.lo) begin
      $error("min_value: expected %0d, got %0d", want.lo, got.lo);
      fails++;
    end
    if (got.hi !== want.hi) begin
      $error("max_value: expected %0d, got %0d", want.hi, got.hi);
      fails++;
    end
    if (got.occ !== want.occ) begin
      $error("occupancy: expected %0d, got %0d", want.occ, got.occ);
      fails++;
    end
    if (got.empt !== want.empt) begin
      $error("is_empty: expected %0b, got %0b", want.empt, got.empt);
      fails++;
    end
  endtask

  // check the result shown in the cycle that just ended, then log any
  // transfer taken at this edge; results come in the cycle after the transfer
  always @(posedge clk) begin : result_check
    depq_result_t got;
    depq_result_t pred;
    if (!rst) begin
      if (done === 1'b1) begin
        got.st        = depq_pkg::status_t'(status);
        got.removed   = removed_value;
        got.match_cnt = match_count;
        got.lo        = min_value;
        got.hi        = max_value;
        got.occ       = occupancy;
        got.empt      = is_empty;
        if (pending_results.size() == 0) begin
          $error("result strobe with no request outstanding");
          fails++;
        end else begin
          compare_result(got, pending_results.pop_front());
        end
      end
      if (start && !busy) begin
        pred = depq_apply(req_type, item_value);
        pending_results.push_back(row_typed ? row_exp : pred);
      end
    end
  end

  function automatic stim_row_t mk_row(logic [depq_pkg::REQ_BITS-1:0] req,
                                       depq_pkg::value_t val, int reps, bit typed,
                                       depq_pkg::status_t st = depq_pkg::ST_OK,
                                       depq_pkg::value_t removed = 0,
                                       int match_cnt = 0, depq_pkg::value_t lo = 0,
                                       depq_pkg::value_t hi = 0, int occ = 0);
    stim_row_t r;
    r.req           = req;
    r.val           = val;
    r.reps          = reps;
    r.typed         = typed;
    r.exp.st        = st;
    r.exp.removed   = removed;
    r.exp.match_cnt = depq_pkg::CNT_FIELD_BITS'(match_cnt);
    r.exp.lo        = lo;
    r.exp.hi        = hi;
    r.exp.occ       = depq_pkg::CNT_FIELD_BITS'(occ);
    r.exp.empt      = (occ == 0);
    return r;
  endfunction

  // drive one request at the falling edge and hold it until the transfer
  task automatic issue(logic [depq_pkg::REQ_BITS-1:0] req, depq_pkg::value_t val,
                       bit typed, depq_result_t want, int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start      <= 1'b1;
    req_type   <= req;
    item_value <= val;
    row_typed  <= typed;
    row_exp    <= want;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  function automatic int idle_gap(int pct);
    int g;
    g = 0;
    while ($urandom_range(99) < pct && g < 8) g++;
    return g;
  endfunction

  // small pool gives duplicates, held values give erase and count hits
  function automatic depq_pkg::value_t pick_value(bit from_store);
    int r;
    r = $urandom_range(99);
    if (from_store && model_vals.size() != 0 && r < 50)
      return model_vals[$urandom_range(model_vals.size() - 1)];
    if (r < 60) return depq_pkg::value_t'($urandom_range(16) - 8);
    if (r < 66) return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    return depq_pkg::value_t'($urandom);
  endfunction

  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    stim_row_t                     dir_rows[$];
    int                            idle_pct[6];
    int                            burst_left;
    int                            p_ins;
    int                            p_pop;
    int                            r;
    int                            drain_cycles;
    mix_t                          mix;
    logic [depq_pkg::REQ_BITS-1:0] req;

    idle_pct = '{0, 45, 15, 45, 0, 15};

    // empty store right after reset
    dir_rows.push_back(mk_row(depq_pkg::REQ_POP_MIN, 0, 1, 1, depq_pkg::ST_EMPTY));
    dir_rows.push_back(mk_row(depq_pkg::REQ_POP_MAX, 0, 1, 1, depq_pkg::ST_EMPTY));
    dir_rows.push_back(mk_row(depq_pkg::REQ_ERASE, 5, 1, 1, depq_pkg::ST_NOT_FOUND));
    dir_rows.push_back(mk_row(depq_pkg::REQ_COUNT, 5, 1, 1, depq_pkg::ST_OK));
    dir_rows.push_back(mk_row(REQ_UNDEF_LO, 32'sh1234, 1, 1, depq_pkg::ST_OK));
    dir_rows.push_back(mk_row(REQ_UNDEF_HI, -1, 1, 1, depq_pkg::ST_OK));
    // value extremes
    dir_rows.push_back(mk_row(depq_pkg::REQ_INSERT, 32'sh7fffffff, 1, 1, depq_pkg::ST_OK,
                              0, 0, 32'sh7fffffff, 32'sh7fffffff, 1));
    dir_rows.push_back(mk_row(depq_pkg::REQ_INSERT, 32'sh80000000, 1, 1, depq_pkg::ST_OK,
                              0, 0, 32'sh80000000, 32'sh7fffffff, 2));
    // duplicates, counts, erase hit and miss, pops at both ends
    dir_rows.push_back(mk_row(depq_pkg::REQ_INSERT, -1, 1, 0));
    dir_rows.push_back(mk_row(depq_pkg::REQ_INSERT, 0, 1, 0));
    dir_rows.push_back(mk_row(depq_pkg::REQ_INSERT, -1, 1, 0));
    dir_rows.push_back(mk_row(depq_pkg::REQ_COUNT, -1, 1, 0));
    dir_rows.push_back(mk_row(depq_pkg::REQ_ERASE, 12345, 1, 0));
    dir_rows.push_back(mk_row(depq_pkg::REQ_ERASE, -1, 1, 0));
    dir_rows.push_back(mk_row(depq_pkg::REQ_POP_MIN, 0, 1, 0));
    dir_rows.push_back(mk_row(depq_pkg::REQ_POP_MAX, 0, 1, 0));
    dir_rows.push_back(mk_row(REQ_UNDEF_LO, 7, 1, 0));
    dir_rows.push_back(mk_row(depq_pkg::REQ_CLEAR, 0, 1, 1, depq_pkg::ST_OK));
    // alternating bit patterns
    dir_rows.push_back(mk_row(depq_pkg::REQ_INSERT, 32'shaaaaaaaa, 1, 0));
    dir_rows.push_back(mk_row(depq_pkg::REQ_INSERT, 32'sh55555555, 1, 0));
    dir_rows.push_back(mk_row(depq_pkg::REQ_CLEAR, 0, 1, 1, depq_pkg::ST_OK));
    // fill with one value, then overflow and count the full store
    dir_rows.push_back(mk_row(depq_pkg::REQ_INSERT, 1, depq_pkg::CAPACITY, 0));
    dir_rows.push_back(mk_row(depq_pkg::REQ_INSERT, 2, 1, 1, depq_pkg::ST_FULL, 0, 0,
                              1, 1, depq_pkg::CAPACITY));
    dir_rows.push_back(mk_row(depq_pkg::REQ_COUNT, 1, 1, 1, depq_pkg::ST_OK, 0,
                              depq_pkg::CAPACITY, 1, 1, depq_pkg::CAPACITY));
    dir_rows.push_back(mk_row(depq_pkg::REQ_ERASE, 1, 1, 0));
    dir_rows.push_back(mk_row(depq_pkg::REQ_CLEAR, 0, 1, 1, depq_pkg::ST_OK));

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k])
      repeat (dir_rows[k].reps)
        issue(dir_rows[k].req, dir_rows[k].val, dir_rows[k].typed, dir_rows[k].exp, 0);

    burst_left = 0;
    mix        = MIX_BALANCED;
    foreach (idle_pct[ph]) begin
      // hold off until every outstanding result is back
      @(negedge clk);
      start <= 1'b0;
      while (pending_results.size() != 0) @(negedge clk);

      repeat (PHASE_ITEMS) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(120, 40);
          mix        = mix_t'($urandom_range(2));
        end
        burst_left--;
        p_ins = (mix == MIX_FILL) ? 75 : (mix == MIX_DRAIN) ? 15 : 40;
        p_pop = (mix == MIX_FILL) ? 8  : (mix == MIX_DRAIN) ? 55 : 25;
        r = $urandom_range(99);
        if (r < p_ins) begin
          req = depq_pkg::REQ_INSERT;
        end else if (r < p_ins + p_pop) begin
          req = $urandom_range(1) ? depq_pkg::REQ_POP_MIN : depq_pkg::REQ_POP_MAX;
        end else if (r < 97) begin
          req = $urandom_range(1) ? depq_pkg::REQ_ERASE : depq_pkg::REQ_COUNT;
        end else if (r < 98) begin
          req = depq_pkg::REQ_CLEAR;
        end else begin
          req = $urandom_range(1) ? REQ_UNDEF_LO : REQ_UNDEF_HI;
        end
        issue(req, pick_value(req == depq_pkg::REQ_ERASE || req == depq_pkg::REQ_COUNT),
              1'b0, row_exp, idle_gap(idle_pct[ph]));
      end
    end

    @(negedge clk);
    start <= 1'b0;
    drain_cycles = 0;
    while (pending_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(negedge clk);
      drain_cycles++;
    end
    // results follow the transfer in the next cycle; the extra wait catches any stray strobe
    repeat (4) @(negedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fails++;
    end
    if (fails == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
